// File: design/sha1sh_pkg.sv
// Shared types and constants for the streaming SHA-1 hasher.
// No dependencies; imported by the controller, the datapath and the top level.
package sha1sh_pkg;

   // initial chaining values
   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hefcdab89;
   localparam logic [31:0] H2_INIT = 32'h98badcfe;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

   // round constants
   localparam logic [31:0] K_RND0 = 32'h5a827999;
   localparam logic [31:0] K_RND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_RND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_RND3 = 32'hca62c1d6;

   // first padding byte
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // byte positions in a block, last round index and last digest word
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   // group of 20 rounds
   typedef enum logic [1:0] {
      RND_CH,
      RND_PAR,
      RND_MAJ,
      RND_PAR2
   } phase_type;

   // source of the byte shifted into the block buffer
   typedef enum logic [1:0] {
      BSEL_MSG,
      BSEL_PAD,
      BSEL_ZERO,
      BSEL_LEN
   } bsel_type;

   // controller to datapath commands
   typedef struct packed {
      logic       shift_byte;
      bsel_type   byte_sel;
      logic [2:0] len_idx;
      logic       count_inc;
      logic       load_work;
      logic       round;
      phase_type  phase;
      logic       add_chain;
      logic       reset_state;
      logic [2:0] word_idx;
   } cmd_type;

   function automatic logic [31:0] round_f(phase_type ph, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
      logic [31:0] res;
      case (ph)
         RND_CH:  res = (b & c) | (~b & d);
         RND_MAJ: res = (b & c) | (b & d) | (c & d);
         default: res = b ^ c ^ d;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] round_k(phase_type ph);
      logic [31:0] res;
      case (ph)
         RND_CH:  res = K_RND0;
         RND_PAR: res = K_RND1;
         RND_MAJ: res = K_RND2;
         default: res = K_RND3;
      endcase
      return res;
   endfunction

endpackage

// File: design/sha1sh_ctrl.sv
// Controller of the SHA-1 hasher: byte gathering, padding, round sequencing
// and digest output. Depends on sha1sh_pkg; drives commands to sha1sh_datapath.
module sha1sh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_byte_present,
   input  logic                req_end_of_message,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word,
   output sha1sh_pkg::cmd_type cmd
);
   import sha1sh_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] widx_ff, widx_in;
   logic       fin_ff, fin_in;
   logic       pad_ff, pad_in;
   logic       first_ff, first_in;
   logic       len_ok_ff, len_ok_in;
   phase_type  phase;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         rnd_ff    <= '0;
         widx_ff   <= '0;
         fin_ff    <= 1'b0;
         pad_ff    <= 1'b0;
         first_ff  <= 1'b0;
         len_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         rnd_ff    <= rnd_in;
         widx_ff   <= widx_in;
         fin_ff    <= fin_in;
         pad_ff    <= pad_in;
         first_ff  <= first_in;
         len_ok_ff <= len_ok_in;
      end
   end

   // round group from the round counter
   always_comb begin
      case (rnd_ff) inside
         [7'd0:7'd19]:  phase = RND_CH;
         [7'd20:7'd39]: phase = RND_PAR;
         [7'd40:7'd59]: phase = RND_MAJ;
         default:       phase = RND_PAR2;
      endcase
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      rnd_in    = rnd_ff;
      widx_in   = widx_ff;
      fin_in    = fin_ff;
      pad_in    = pad_ff;
      first_in  = first_ff;
      len_ok_in = len_ok_ff;

      cmd             = '0;
      cmd.byte_sel    = BSEL_MSG;
      cmd.phase       = phase;
      cmd.word_idx    = widx_ff;
      cmd.len_idx     = fill_ff[2:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present) begin
                  cmd.shift_byte = 1'b1;
                  cmd.count_inc  = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == LAST_POS) begin
                     // full block: compress, finish afterwards if marked
                     state_in      = ST_ROUND;
                     cmd.load_work = 1'b1;
                     rnd_in        = '0;
                     fin_in        = req_end_of_message;
                     pad_in        = 1'b0;
                  end else if (req_end_of_message) begin
                     state_in  = ST_PAD;
                     pad_in    = 1'b1;
                     first_in  = 1'b1;
                     len_ok_in = (fill_ff < 6'd55);
                  end
               end else if (req_end_of_message) begin
                  state_in  = ST_PAD;
                  pad_in    = 1'b1;
                  first_in  = 1'b1;
                  len_ok_in = (fill_ff < LEN_POS);
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            if (pad_ff) begin
               if (len_ok_ff) begin
                  state_in = ST_EMIT;
                  widx_in  = '0;
               end else begin
                  // 0x80 left no room for the length field: one more block
                  state_in  = ST_PAD;
                  first_in  = 1'b0;
                  len_ok_in = 1'b1;
               end
            end else if (fin_ff) begin
               state_in  = ST_PAD;
               fin_in    = 1'b0;
               pad_in    = 1'b1;
               first_in  = 1'b1;
               len_ok_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.shift_byte = 1'b1;
            if (first_ff) begin
               cmd.byte_sel = BSEL_PAD;
            end else if (len_ok_ff && (fill_ff >= LEN_POS)) begin
               cmd.byte_sel = BSEL_LEN;
            end else begin
               cmd.byte_sel = BSEL_ZERO;
            end
            first_in = 1'b0;
            fill_in  = fill_ff + 6'd1;
            if (fill_ff == LAST_POS) begin
               state_in      = ST_ROUND;
               cmd.load_work = 1'b1;
               rnd_in        = '0;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == LAST_WORD) begin
                  cmd.reset_state = 1'b1;
                  state_in        = ST_IDLE;
                  widx_in         = '0;
                  pad_in          = 1'b0;
                  fin_in          = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_word_index = widx_ff;
   assign rsp_last_word  = (widx_ff == LAST_WORD);

endmodule

// File: design/sha1sh_datapath.sv
// Datapath of the SHA-1 hasher: block shift line, message schedule, round
// registers, chaining words and bit count. Depends on sha1sh_pkg.
module sha1sh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sha1sh_pkg::cmd_type cmd,
   input  logic [7:0]          req_data_byte,
   output logic [31:0]         rsp_digest_word
);
   import sha1sh_pkg::*;

   // block buffer: word 0 of the schedule window sits in the top 32 bits
   logic [511:0] blk_ff, blk_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  h0_ff, h1_ff, h2_ff, h3_ff, h4_ff;
   logic [60:0]  cnt_ff, cnt_in;
   logic [7:0]   byte_in;
   logic [63:0]  len_shifted;
   logic [31:0]  w_cur, w_mix, w_new, t_in;

   // length field bytes, most significant first
   assign len_shifted = {cnt_ff, 3'b000} << {cmd.len_idx, 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BSEL_MSG: byte_in = req_data_byte;
         BSEL_PAD: byte_in = PAD_BYTE;
         BSEL_LEN: byte_in = len_shifted[63:56];
         default:  byte_in = 8'h00;
      endcase
   end

   // schedule: w[r+16] = rotl1(w[r+13] ^ w[r+8] ^ w[r+2] ^ w[r])
   assign w_cur = blk_ff[511:480];
   assign w_mix = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ w_cur;
   assign w_new = {w_mix[30:0], w_mix[31]};

   // one round
   assign t_in = {a_ff[26:0], a_ff[31:27]} + round_f(cmd.phase, b_ff, c_ff, d_ff)
                 + e_ff + round_k(cmd.phase) + w_cur;

   always_comb begin
      blk_in = blk_ff;
      if (cmd.shift_byte) begin
         blk_in = {blk_ff[503:0], byte_in};
      end else if (cmd.round) begin
         blk_in = {blk_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   // working variables
   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         a_ff <= h0_ff;
         b_ff <= h1_ff;
         c_ff <= h2_ff;
         d_ff <= h3_ff;
         e_ff <= h4_ff;
      end else if (cmd.round) begin
         a_ff <= t_in;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   // chaining words
   always_ff @(posedge clock) begin
      if (reset || cmd.reset_state) begin
         h0_ff <= H0_INIT;
         h1_ff <= H1_INIT;
         h2_ff <= H2_INIT;
         h3_ff <= H3_INIT;
         h4_ff <= H4_INIT;
      end else if (cmd.add_chain) begin
         h0_ff <= h0_ff + a_ff;
         h1_ff <= h1_ff + b_ff;
         h2_ff <= h2_ff + c_ff;
         h3_ff <= h3_ff + d_ff;
         h4_ff <= h4_ff + e_ff;
      end
   end

   // message byte count; bit count is this times eight, wrapping mod 2^64
   assign cnt_in = cnt_ff + 61'd1;

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_state) begin
         cnt_ff <= '0;
      end else if (cmd.count_inc) begin
         cnt_ff <= cnt_in;
      end
   end

   // digest word select
   always_comb begin
      case (cmd.word_idx)
         3'd0:    rsp_digest_word = h0_ff;
         3'd1:    rsp_digest_word = h1_ff;
         3'd2:    rsp_digest_word = h2_ff;
         3'd3:    rsp_digest_word = h3_ff;
         default: rsp_digest_word = h4_ff;
      endcase
   end

endmodule

// File: design/sha1_stream_hasher.sv
// Streaming SHA-1 hasher, top level.
// Usage:
//  - req channel: one beat per call, carrying an optional message byte
//    (req_byte_present) and an optional end-of-message mark.
//  - rsp channel: five beats per message, digest words 0..4 in order,
//    rsp_last_word high on word 4.
// Operation:
//  - A message byte is taken while idle; the byte that fills a 64-byte block
//    starts 80 rounds in one shared round unit, then the chaining add,
//    during which req_stall is high.
//  - End of message: 64 - fill pad bytes at one a cycle (plus another 64 if
//    the 0x80 lands at byte 56 or later), each padding block then runs the
//    rounds and the chaining add, then the first digest beat the next cycle.
// Stall: a stalled digest beat holds its word; the block waits in the
//  output state and takes no new beat until word 4 is taken.
// Reset: synchronous, active high; loads the initial chaining values and
//  clears the fill and bit count. After each digest the same state returns.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_datapath.
module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1sh_pkg::*;

   cmd_type cmd;

   sha1sh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .cmd                (cmd)
   );

   sha1sh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule
